// ===== rtl/rlf_pkg.sv =====
package rlf_pkg;

	localparam int VAL_W = 11;
	localparam int LEN_W = 11;
	// Walk pointer: one bit wider than a value, so that the update step can pass the size.
	localparam int POS_W = VAL_W + 1;
	localparam int TDATA_W = 16;
	localparam int MAX_VALUES_DEF = 1024;

	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
	localparam logic [VAL_W-1:0] SIZE_RESET = 11'd1024;

	typedef struct packed {
		logic clear;
		logic load;
		logic query;
		logic to_update;
		logic update;
		logic emit;
	} rlf_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic in_range;
		logic q_done;
		logic u_done;
		logic pend;
		logic out_free;
	} rlf_sts_t;

endpackage

// ===== rtl/running_lis_length_fenwick_top.sv =====
// Running longest-increasing-subsequence length over a stream of ranks.
// The slave channel takes one value per item; the master channel returns one
// result per item, the best length so far and a rejected flag for a value of
// zero or above the active size as capped at MAX_VALUES. Rejected items leave
// all state unchanged. cfg_we/cfg_wdata set the active size; write it only
// while the block is idle. An item is processed one at a time: accept, then
// the prefix-max query walk with popcount(value-1) reads, then the update walk
// with one read per visited tree node, then the result. At the full size of
// 1024 the two walks always make eleven reads between them; a smaller active
// size shortens the update walk. The next item is taken only after the result
// has been loaded into the output register. A rejected item skips both walks
// and goes from acceptance straight to the result state.
// The result sits in an output register, so a stalled receiver does not stop
// the next item from being accepted and walked; only the next result waits.
// After reset the tree memory is cleared, one entry per cycle over MAX_VALUES
// entries, with s_tready low; configuration writes are taken during that pass.
module running_lis_length_fenwick_top
	import rlf_pkg::*;
#(
	parameter int MAX_VALUES = MAX_VALUES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [VAL_W-1:0]   cfg_wdata,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,  // [10:0] value
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,  // [10:0] lis_length
	output logic [0:0]         m_tuser   // [0] rejected
);

	rlf_cmd_t         cmd;
	rlf_sts_t         sts;
	logic [LEN_W-1:0] out_len;
	logic             out_rej;

	rlf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	rlf_dp #(
		.MAX_VALUES(MAX_VALUES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_value (s_tdata[VAL_W-1:0]),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.out_len  (out_len),
		.out_rej  (out_rej),
		.cmd      (cmd),
		.sts      (sts)
	);

	assign m_tdata = TDATA_W'(out_len);
	assign m_tuser = out_rej;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result loaded over an untaken result");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !sts.pend)
		else $error("item loaded while a tree read is in flight");

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear, cmd.load, cmd.query, cmd.to_update, cmd.update, cmd.emit}))
		else $error("conflicting datapath commands");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_tvalid)
		else $error("emitted result not presented");

endmodule

// ===== rtl/rlf_ram.sv =====
module rlf_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/rlf_ctrl.sv =====
module rlf_ctrl
	import rlf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  rlf_sts_t  sts,
	output rlf_cmd_t  cmd
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_QUERY  = 3'd2;
	localparam logic [2:0] ST_UPDATE = 3'd3;
	localparam logic [2:0] ST_RESULT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d = sts.in_range ? ST_QUERY : ST_RESULT;
				end
			end
			ST_QUERY: begin
				// Leave only once the last read of the walk has been merged.
				if (sts.q_done && !sts.pend) begin
					cmd.to_update = 1'b1;
					state_d = ST_UPDATE;
				end else begin
					cmd.query = 1'b1;
				end
			end
			ST_UPDATE: begin
				// Keep the update command up so the final pending write still lands.
				cmd.update = 1'b1;
				if (sts.u_done && !sts.pend) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/rlf_dp.sv =====
module rlf_dp
	import rlf_pkg::*;
#(
	parameter int MAX_VALUES = MAX_VALUES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [VAL_W-1:0]   cfg_wdata,
	input  logic [VAL_W-1:0]   in_value,
	input  logic               m_tready,
	output logic               m_tvalid,
	output logic [LEN_W-1:0]   out_len,
	output logic               out_rej,
	input  rlf_cmd_t           cmd,
	output rlf_sts_t           sts
);

	localparam int ADDR_W = $clog2(MAX_VALUES);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_VALUES - 1);

	logic [VAL_W-1:0]  size_q;
	logic [POS_W-1:0]  eff_size;
	logic [VAL_W-1:0]  val_q;
	logic [POS_W-1:0]  j_q;
	logic [LEN_W-1:0]  acc_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  best_q;
	logic              rej_q;
	logic              pend_q;
	logic [ADDR_W-1:0] pend_addr_q;
	logic [ADDR_W-1:0] clr_q;
	logic              out_valid_q;
	logic [LEN_W-1:0]  out_len_q;
	logic              out_rej_q;

	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [LEN_W-1:0]  rd_data;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [LEN_W-1:0]  wr_data;
	logic [POS_W-1:0]  j_low;
	logic [POS_W-1:0]  in_pos;
	logic [LEN_W-1:0]  len_next;

	always_comb begin
		if (32'(size_q) > MAX_VALUES) begin
			eff_size = POS_W'(MAX_VALUES);
		end else begin
			eff_size = POS_W'(size_q);
		end
	end

	assign in_pos = POS_W'(in_value);
	assign j_low = j_q & (~j_q + POS_W'(1));
	assign len_next = (acc_q == LEN_MAX) ? acc_q : acc_q + LEN_W'(1);

	assign sts.clear_last = (clr_q == LAST_ADDR);
	assign sts.in_range = (in_pos != '0) && (in_pos <= eff_size);
	assign sts.q_done = (j_q == '0);
	assign sts.u_done = (j_q == '0) || (j_q > eff_size);
	assign sts.pend = pend_q;
	assign sts.out_free = !out_valid_q || m_tready;

	assign rd_en = (cmd.query && !sts.q_done) || (cmd.update && !sts.u_done);
	assign rd_addr = ADDR_W'(j_q - POS_W'(1));

	// The clearing pass and the update writes never overlap in time.
	always_comb begin
		if (cmd.clear) begin
			wr_en = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else begin
			wr_en = cmd.update && pend_q && (rd_data < len_q);
			wr_addr = pend_addr_q;
			wr_data = len_q;
		end
	end

	rlf_ram #(
		.WIDTH(LEN_W),
		.DEPTH(MAX_VALUES)
	) u_tree (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk) begin
		pend_addr_q <= rd_addr;
		if (cmd.load) begin
			val_q <= in_value;
			j_q <= in_pos - POS_W'(1);
			acc_q <= '0;
			rej_q <= !sts.in_range;
		end else if (cmd.to_update) begin
			j_q <= POS_W'(val_q);
			len_q <= len_next;
		end else if (rd_en) begin
			// Query walks down by clearing the low bit; update walks up by adding it.
			j_q <= cmd.query ? (j_q & (j_q - POS_W'(1))) : (j_q + j_low);
		end
		if (cmd.query && pend_q && (rd_data > acc_q)) begin
			acc_q <= rd_data;
		end
		if (cmd.emit) begin
			out_rej_q <= rej_q;
			out_len_q <= (!rej_q && (len_q > best_q)) ? len_q : best_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
			best_q <= '0;
			pend_q <= 1'b0;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_wdata;
			end
			pend_q <= rd_en;
			if (cmd.clear) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (!rej_q && (len_q > best_q)) begin
					best_q <= len_q;
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign out_len = out_len_q;
	assign out_rej = out_rej_q;

endmodule

// ===== test/running_lis_length_checker.sv =====
`timescale 1ns / 1ps

module running_lis_length_checker
	import rlf_pkg::*;
#(
	parameter int MAX_VALUES = MAX_VALUES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [VAL_W-1:0]   cfg_wdata,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,  // [10:0] value
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [TDATA_W-1:0] m_tdata,  // [10:0] lis_length
	input  logic [0:0]         m_tuser,  // [0] rejected
	output int                 fail_count,
	output int                 pending,
	output int                 checked,
	output int                 rejected_seen,
	output logic [LEN_W-1:0]   peak_len
);

	typedef struct packed {
		logic [LEN_W-1:0] lis_length;
		logic             rejected;
	} lis_result_t;

	logic [LEN_W-1:0] run_tree [MAX_VALUES];
	logic [LEN_W-1:0] best_run;
	logic [VAL_W-1:0] size_reg;
	lis_result_t      awaited_results [$];
	lis_result_t      want;
	int               errs;
	int               n_checked;
	int               n_rejected;

	// Updates the prefix-max tree for one value and returns the result the block must give.
	function automatic lis_result_t predict_lis(input logic [VAL_W-1:0] v);
		int unsigned eff;
		int unsigned j;
		int unsigned run;
		lis_result_t r;
		eff = (size_reg > MAX_VALUES) ? MAX_VALUES : size_reg;
		r.rejected = (v == 0) || (v > eff);
		if (!r.rejected) begin
			run = 0;
			j = v - 1;
			while (j > 0) begin
				if (j <= MAX_VALUES && run_tree[j-1] > run)
					run = run_tree[j-1];
				j -= j & (~j + 1);
			end
			if (run < LEN_MAX)
				run++;
			// The update walk stops past the effective size, not past the tree depth.
			j = v;
			while (j > 0 && j <= eff) begin
				if (run_tree[j-1] < run)
					run_tree[j-1] = LEN_W'(run);
				j += j & (~j + 1);
			end
			if (run > best_run)
				best_run = LEN_W'(run);
		end
		r.lis_length = best_run;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_VALUES; i++)
				run_tree[i] = '0;
			best_run = '0;
			size_reg = SIZE_RESET;
			awaited_results.delete();
			errs = 0;
			n_checked = 0;
			n_rejected = 0;
		end else begin
			if (cfg_we)
				size_reg = cfg_wdata;
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result: lis_length %0d, rejected %0d",
						m_tdata[LEN_W-1:0], m_tuser[0]);
					errs++;
				end else begin
					want = awaited_results.pop_front();
					n_checked++;
					if (m_tuser[0])
						n_rejected++;
					if (m_tdata[LEN_W-1:0] !== want.lis_length) begin
						$error("lis_length: expected %0d, actual %0d",
							want.lis_length, m_tdata[LEN_W-1:0]);
						errs++;
					end
					if (m_tuser[0] !== want.rejected) begin
						$error("rejected: expected %0d, actual %0d", want.rejected, m_tuser[0]);
						errs++;
					end
				end
			end
			if (s_tvalid && s_tready)
				awaited_results.push_back(predict_lis(s_tdata[VAL_W-1:0]));
		end
		pending <= awaited_results.size();
		fail_count <= errs;
		checked <= n_checked;
		rejected_seen <= n_rejected;
		peak_len <= best_run;
	end

endmodule

// ===== test/tb_running_lis_length_fenwick_top.sv =====
`timescale 1ns / 1ps

module tb_running_lis_length_fenwick_top
	import rlf_pkg::*;
;

	// Cycles without any transfer on either channel before the run is called hung; covers the clearing pass.
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 30;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct {
		int unsigned size;
		int unsigned count;
		bit          ascend;
		idle_mode_t  idle;
	} phase_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [VAL_W-1:0]   cfg_wdata = '0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic [0:0]         m_tuser;

	int               fail_count;
	int               pending;
	int               checked;
	int               rejected_seen;
	logic [LEN_W-1:0] peak_len;

	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          size_writes = 0;
	int unsigned deck [MAX_VALUES_DEF];

	always #1 clk = ~clk;

	running_lis_length_fenwick_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	running_lis_length_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked       (checked),
		.rejected_seen (rejected_seen),
		.peak_len      (peak_len)
	);

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Valid stays high from one item to the next unless an idle cycle is rolled.
	task automatic push_value(input logic [VAL_W-1:0] v);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= TDATA_W'(v);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(input logic [VAL_W-1:0] sz);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= sz;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_writes++;
	endtask

	task automatic shuffle_deck(input int unsigned n);
		int unsigned k;
		int unsigned t;
		int unsigned tmp;
		for (k = n; k > 1; k--) begin
			t = $urandom_range(k - 1);
			tmp = deck[k-1];
			deck[k-1] = deck[t];
			deck[t] = tmp;
		end
	endtask

	initial begin
		phase_t      plan [9];
		int unsigned eff;
		int unsigned pos;
		int unsigned cur;
		int unsigned v;
		int unsigned roll;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed items at the reset size, then at the empty, smallest and saturated sizes.
		push_value(11'd0);
		push_value(11'd2047);
		push_value(11'd1025);
		push_value(11'd1024);
		push_value(11'd1);
		push_value(11'd1023);
		push_value(11'd512);
		push_value(11'd2);
		push_value(11'd1024);
		push_value(11'd1);
		write_size(11'd0);
		push_value(11'd1);
		push_value(11'd0);
		push_value(11'd1024);
		write_size(11'd1);
		push_value(11'd1);
		push_value(11'd2);
		push_value(11'd1);
		push_value(11'd0);
		write_size(11'd2047);
		push_value(11'd1024);
		push_value(11'd1025);
		push_value(11'd2047);
		push_value(11'd3);

		plan[0] = '{1024, 150, 1'b0, IDLE_NONE};
		plan[1] = '{8, 100, 1'b0, IDLE_SEND};
		plan[2] = '{2, 50, 1'b0, IDLE_RECV};
		plan[3] = '{1, 30, 1'b0, IDLE_BOTH};
		plan[4] = '{0, 25, 1'b0, IDLE_SEND};
		plan[5] = '{2047, 150, 1'b0, IDLE_RECV};
		plan[6] = '{$urandom_range(3, 1000), 120, 1'b0, IDLE_BOTH};
		plan[7] = '{1025, 80, 1'b0, IDLE_NONE};
		// A long ascending run drives the length up to the full size.
		plan[8] = '{1024, 1100, 1'b1, IDLE_BOTH};

		foreach (plan[p]) begin
			write_size(plan[p].size[VAL_W-1:0]);
			case (plan[p].idle)
				IDLE_NONE: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				IDLE_SEND: begin
					send_idle_pct = 54;
					recv_stall_pct = 0;
				end
				IDLE_RECV: begin
					send_idle_pct = 0;
					recv_stall_pct = 54;
				end
				default: begin
					send_idle_pct = 14;
					recv_stall_pct = 14;
				end
			endcase
			eff = (plan[p].size > MAX_VALUES_DEF) ? MAX_VALUES_DEF : plan[p].size;
			for (int k = 0; k < eff; k++)
				deck[k] = k + 1;
			shuffle_deck(eff);
			pos = 0;
			cur = 1;
			repeat (plan[p].count) begin
				roll = $urandom_range(99);
				if (eff == 0 || roll < 6) begin
					v = $urandom_range(2047);
				end else if (!plan[p].ascend && roll < 12) begin
					case ($urandom_range(2))
						0: v = 0;
						1: v = eff;
						default: v = eff + 1;
					endcase
				end else if (plan[p].ascend) begin
					v = cur;
					cur = (cur >= eff) ? 1 : cur + 1;
				end else begin
					v = deck[pos];
					pos++;
					if (pos == eff) begin
						shuffle_deck(eff);
						pos = 0;
					end
				end
				push_value(v[VAL_W-1:0]);
			end
		end

		wait_idle();
		$display("Checked %0d results over %0d size settings, %0d of them for refused values.",
			checked, size_writes + 1, rejected_seen);
		$display("Longest increasing run reached %0d.", peak_len);
		if (fail_count == 0 && pending == 0)
			$display("** running_lis_length_fenwick_top: PASSED **");
		else
			$display("** running_lis_length_fenwick_top: FAILED **");
		$finish;
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Run stopped after %0d cycles without a transfer.", STALL_LIMIT);
		$display("** running_lis_length_fenwick_top: FAILED **");
		$finish;
	end

endmodule

// ===== running_lis_length_fenwick_top.f =====
rtl/rlf_pkg.sv
rtl/rlf_ram.sv
rtl/rlf_ctrl.sv
rtl/rlf_dp.sv
rtl/running_lis_length_fenwick_top.sv
test/running_lis_length_checker.sv
test/tb_running_lis_length_fenwick_top.sv
